// ===== hdl/plsr_pkg.sv =====
`default_nettype none

package plsr_pkg;

    // Register map, one 32-bit word per register
    typedef enum logic [2:0] {
        REG_GOAL_POSITION       = 3'd0,
        REG_ERROR_DEADBAND      = 3'd1,
        REG_INTEGRAL_LIMIT      = 3'd2,
        REG_KP_GAIN             = 3'd3,
        REG_KI_GAIN             = 3'd4,
        REG_CORRECTION_DEADBAND = 3'd5,
        REG_BASE_SPEED          = 3'd6
    } t_reg_idx;

    localparam int IMAGE_WIDTH = 640;

    localparam int POS_W   = 10;
    localparam int DB_W    = 10;
    localparam int LIM_W   = 16;
    localparam int GAIN_W  = 20;
    localparam int CDB_W   = 15;
    localparam int SPD_W   = 16;
    localparam int ERR_W   = POS_W + 1;
    localparam int INTEG_W = 18;
    localparam int PK_W    = GAIN_W + 1 + ERR_W;
    localparam int PI_W    = GAIN_W + 1 + INTEG_W;
    localparam int FRAC_W  = 16;
    localparam int Q_W     = PI_W - FRAC_W;

    localparam logic [POS_W-1:0] GOAL_RST   = POS_W'(IMAGE_WIDTH / 2);
    localparam logic [DB_W-1:0]  ERR_DB_RST = 10'd15;
    localparam logic [LIM_W-1:0] LIMIT_RST  = 16'd30000;
    localparam logic [SPD_W-1:0] BASE_RST   = 16'd400;

    localparam logic signed [SPD_W-1:0] SPD_MAX = 16'sh7FFF;
    localparam logic signed [SPD_W-1:0] SPD_MIN = 16'sh8000;

endpackage

`default_nettype wire

// ===== hdl/pi_line_steering_regulator.sv =====
`default_nettype none

// Channel   Direction  Beat                       Handshake
// -------   ---------  -------------------------  ------------------------
// in        input      line pos (10b)             i_in_valid / o_in_ready
// out       output     correction, right, left    o_out_valid / i_out_ready
// apb       input      register write / read      psel, penable, pwrite
//
// Five register stages, one beat per cycle sustained while the output is not
// held. Stage 1 holds the only loop: error, deadband test and integral
// add-and-clamp on the accepted beat.
// Stalls: a stage loads when empty or when the stage after it moves, so
// bubbles collapse and a held output still lets earlier stages fill.
// Reset (synchronous, active low) clears the integral and valids and loads register defaults.
module pi_line_steering_regulator (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    // input beats
    input  wire                           i_in_valid,
    output logic                          o_in_ready,
    input  wire  [plsr_pkg::POS_W-1:0]    i_line_pos,
    // result beats
    output logic                          o_out_valid,
    input  wire                           i_out_ready,
    output logic signed [plsr_pkg::SPD_W-1:0] o_correction,
    output logic signed [plsr_pkg::SPD_W-1:0] o_right_speed,
    output logic signed [plsr_pkg::SPD_W-1:0] o_left_speed,
    // register port
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire  [4:0]                    paddr,
    input  wire  [31:0]                   pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam int POS_W   = plsr_pkg::POS_W;
    localparam int DB_W    = plsr_pkg::DB_W;
    localparam int LIM_W   = plsr_pkg::LIM_W;
    localparam int GAIN_W  = plsr_pkg::GAIN_W;
    localparam int CDB_W   = plsr_pkg::CDB_W;
    localparam int SPD_W   = plsr_pkg::SPD_W;
    localparam int ERR_W   = plsr_pkg::ERR_W;
    localparam int INTEG_W = plsr_pkg::INTEG_W;
    localparam int PK_W    = plsr_pkg::PK_W;
    localparam int PI_W    = plsr_pkg::PI_W;
    localparam int FRAC_W  = plsr_pkg::FRAC_W;
    localparam int Q_W     = plsr_pkg::Q_W;

    // ------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------
    logic [POS_W-1:0]         r_goal;
    logic [DB_W-1:0]          r_err_db;
    logic [LIM_W-1:0]         r_limit;
    logic [GAIN_W-1:0]        r_kp;
    logic [GAIN_W-1:0]        r_ki;
    logic [CDB_W-1:0]         r_corr_db;
    logic signed [SPD_W-1:0]  r_base;

    plsr_pkg::t_reg_idx       w_idx;
    logic                     w_wr;

    assign pready = 1'b1;
    assign w_idx  = plsr_pkg::t_reg_idx'(paddr[4:2]);
    assign w_wr   = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_goal    <= plsr_pkg::GOAL_RST;
            r_err_db  <= plsr_pkg::ERR_DB_RST;
            r_limit   <= plsr_pkg::LIMIT_RST;
            r_kp      <= '0;
            r_ki      <= '0;
            r_corr_db <= '0;
            r_base    <= plsr_pkg::BASE_RST;
        end else if (w_wr) begin
            unique case (w_idx)
                plsr_pkg::REG_GOAL_POSITION:       r_goal    <= pwdata[POS_W-1:0];
                plsr_pkg::REG_ERROR_DEADBAND:      r_err_db  <= pwdata[DB_W-1:0];
                plsr_pkg::REG_INTEGRAL_LIMIT:      r_limit   <= pwdata[LIM_W-1:0];
                plsr_pkg::REG_KP_GAIN:             r_kp      <= pwdata[GAIN_W-1:0];
                plsr_pkg::REG_KI_GAIN:             r_ki      <= pwdata[GAIN_W-1:0];
                plsr_pkg::REG_CORRECTION_DEADBAND: r_corr_db <= pwdata[CDB_W-1:0];
                plsr_pkg::REG_BASE_SPEED:          r_base    <= pwdata[SPD_W-1:0];
                default: ; // unmapped word, write dropped
            endcase
        end
    end

    always_comb begin
        unique case (w_idx)
            plsr_pkg::REG_GOAL_POSITION:       prdata = 32'(r_goal);
            plsr_pkg::REG_ERROR_DEADBAND:      prdata = 32'(r_err_db);
            plsr_pkg::REG_INTEGRAL_LIMIT:      prdata = 32'(r_limit);
            plsr_pkg::REG_KP_GAIN:             prdata = 32'(r_kp);
            plsr_pkg::REG_KI_GAIN:             prdata = 32'(r_ki);
            plsr_pkg::REG_CORRECTION_DEADBAND: prdata = 32'(r_corr_db);
            plsr_pkg::REG_BASE_SPEED:          prdata = {16'd0, r_base};
            default:                           prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control
    // ------------------------------------------------------------------
    logic r_v1, r_v2, r_v3, r_v4, r_v5;
    logic w_rdy1, w_rdy2, w_rdy3, w_rdy4, w_rdy5;
    logic w_acc;

    assign w_rdy5     = !r_v5 || i_out_ready;
    assign w_rdy4     = !r_v4 || w_rdy5;
    assign w_rdy3     = !r_v3 || w_rdy4;
    assign w_rdy2     = !r_v2 || w_rdy3;
    assign w_rdy1     = !r_v1 || w_rdy2;
    assign o_in_ready = w_rdy1;
    assign w_acc      = i_in_valid && w_rdy1;
    assign o_out_valid = r_v5;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
            r_v5 <= 1'b0;
        end else begin
            if (w_rdy1) r_v1 <= i_in_valid;
            if (w_rdy2) r_v2 <= r_v1;
            if (w_rdy3) r_v3 <= r_v2;
            if (w_rdy4) r_v4 <= r_v3;
            if (w_rdy5) r_v5 <= r_v4;
        end
    end

    // ------------------------------------------------------------------
    // Stage 1: error, deadband, integral add and clamp
    // ------------------------------------------------------------------
    logic signed [INTEG_W-1:0] r_integral;
    logic signed [ERR_W-1:0]   n_err;
    logic [ERR_W-1:0]          n_mag;
    logic                      n_reg;
    logic signed [INTEG_W-1:0] n_sum;
    logic signed [INTEG_W-1:0] n_lim;
    logic signed [INTEG_W-1:0] n_lim_neg;
    logic signed [INTEG_W-1:0] n_integral;

    logic signed [ERR_W-1:0]   r1_err;
    logic signed [INTEG_W-1:0] r1_acc;
    logic                      r1_reg;

    always_comb begin
        n_err     = $signed({1'b0, i_line_pos}) - $signed({1'b0, r_goal});
        n_mag     = n_err[ERR_W-1] ? (ERR_W'(0) - n_err) : n_err;
        n_reg     = n_mag >= {1'b0, r_err_db};
        n_sum     = r_integral + {{(INTEG_W-ERR_W){n_err[ERR_W-1]}}, n_err};
        n_lim     = $signed({{(INTEG_W-LIM_W){1'b0}}, r_limit});
        n_lim_neg = -n_lim;
        priority if (n_sum > n_lim) begin
            n_integral = n_lim;
        end else if (n_sum < n_lim_neg) begin
            n_integral = n_lim_neg;
        end else begin
            n_integral = n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_integral <= '0;
        end else if (w_acc && n_reg) begin
            r_integral <= n_integral;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_acc) begin
            r1_err <= n_err;
            r1_acc <= n_integral;
            r1_reg <= n_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: the two gain products
    // ------------------------------------------------------------------
    logic signed [PK_W-1:0] n_pk;
    logic signed [PI_W-1:0] n_pi;
    logic signed [PK_W-1:0] r2_pk;
    logic signed [PI_W-1:0] r2_pi;
    logic                   r2_reg;

    assign n_pk = $signed({1'b0, r_kp}) * r1_err;
    assign n_pi = $signed({1'b0, r_ki}) * r1_acc;

    always_ff @(posedge i_clk) begin
        if (w_rdy2 && r_v1) begin
            r2_pk  <= n_pk;
            r2_pi  <= n_pi;
            r2_reg <= r1_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: sum of products
    // ------------------------------------------------------------------
    logic signed [PI_W-1:0] r3_sum;
    logic                   r3_reg;

    always_ff @(posedge i_clk) begin
        if (w_rdy3 && r_v2) begin
            r3_sum <= r2_pi + {{(PI_W-PK_W){r2_pk[PK_W-1]}}, r2_pk};
            r3_reg <= r2_reg;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: shift toward zero, saturate, correction deadband
    // ------------------------------------------------------------------
    logic signed [PI_W-1:0]  n_biased;
    logic signed [Q_W-1:0]   n_q;
    logic signed [SPD_W-1:0] n_sat;
    logic [SPD_W:0]          n_cmag;
    logic signed [SPD_W-1:0] n_corr;
    logic signed [SPD_W-1:0] r4_corr;

    always_comb begin
        // add 2^16-1 on negatives so the arithmetic shift truncates toward zero
        n_biased = r3_sum + (r3_sum[PI_W-1] ? PI_W'({FRAC_W{1'b1}}) : PI_W'(0));
        n_q      = n_biased[PI_W-1:FRAC_W];
        priority if (n_q > Q_W'(plsr_pkg::SPD_MAX)) begin
            n_sat = plsr_pkg::SPD_MAX;
        end else if (n_q < Q_W'(plsr_pkg::SPD_MIN)) begin
            n_sat = plsr_pkg::SPD_MIN;
        end else begin
            n_sat = n_q[SPD_W-1:0];
        end
        n_cmag = n_sat[SPD_W-1] ? ((SPD_W+1)'(0) - {n_sat[SPD_W-1], n_sat})
                                : {1'b0, n_sat};
        if (!r3_reg || (n_cmag < {2'b00, r_corr_db})) begin
            n_corr = '0;
        end else begin
            n_corr = n_sat;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy4 && r_v3) begin
            r4_corr <= n_corr;
        end
    end

    // ------------------------------------------------------------------
    // Stage 5: differential wheel speeds, output register
    // ------------------------------------------------------------------
    logic signed [SPD_W:0]   n_rsum;
    logic signed [SPD_W:0]   n_lsum;
    logic signed [SPD_W-1:0] n_right;
    logic signed [SPD_W-1:0] n_left;

    always_comb begin
        n_rsum = {r_base[SPD_W-1], r_base} - {r4_corr[SPD_W-1], r4_corr};
        n_lsum = {r_base[SPD_W-1], r_base} + {r4_corr[SPD_W-1], r4_corr};
        // top two bits differ: overflowed, clip toward the true sign
        if (n_rsum[SPD_W] != n_rsum[SPD_W-1]) begin
            n_right = n_rsum[SPD_W] ? plsr_pkg::SPD_MIN : plsr_pkg::SPD_MAX;
        end else begin
            n_right = n_rsum[SPD_W-1:0];
        end
        if (n_lsum[SPD_W] != n_lsum[SPD_W-1]) begin
            n_left = n_lsum[SPD_W] ? plsr_pkg::SPD_MIN : plsr_pkg::SPD_MAX;
        end else begin
            n_left = n_lsum[SPD_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy5 && r_v4) begin
            o_correction  <= r4_corr;
            o_right_speed <= n_right;
            o_left_speed  <= n_left;
        end
    end

    // ------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------
    a_integral_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !w_acc |=> $stable(r_integral))
        else $error("integral moved without an accepted beat");

    a_integral_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_integral <= $signed(INTEG_W'(65535))) && (r_integral >= -$signed(INTEG_W'(65535))))
        else $error("integral outside the widest clamp");

    a_zero_corr_speeds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && (o_correction == '0)) |->
            ((o_right_speed == r_base) && (o_left_speed == r_base)))
        else $error("zero correction but speeds differ from base");

endmodule

`default_nettype wire
